// ===== src/rstc_pkg.sv =====
package rstc_pkg;

	// solid corner codes
	localparam logic [1:0] DIR_SW = 2'd0;
	localparam logic [1:0] DIR_NE = 2'd1;
	localparam logic [1:0] DIR_SE = 2'd2;
	localparam logic [1:0] DIR_NW = 2'd3;

	// deform modes, anything else acts as full slope
	localparam logic [2:0] MODE_FULL        = 3'd0;
	localparam logic [2:0] MODE_LEFT_HALF   = 3'd1;
	localparam logic [2:0] MODE_RIGHT_HALF  = 3'd2;
	localparam logic [2:0] MODE_BOTTOM_HALF = 3'd3;
	localparam logic [2:0] MODE_TOP_HALF    = 3'd4;

	// control word handed down the divider chain
	typedef struct packed {
		logic valid;
		logic hit;
		logic x_neg;
		logic y_neg;
	} rstc_ctl_t;

endpackage

// ===== src/rstc_div_cell.sv =====
module rstc_div_cell #(
	parameter int REMW   = 63,
	parameter int NNW    = 42,
	parameter int QB     = 22,
	parameter int SIDE_W = 40,
	parameter int SH     = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  rstc_pkg::rstc_ctl_t   ctl_in,
	input  logic [SIDE_W-1:0]     side_in,
	input  logic [NNW-1:0]        den_in,
	input  logic [REMW-1:0]       rem_x_in,
	input  logic [REMW-1:0]       rem_y_in,
	input  logic [QB-1:0]         q_x_in,
	input  logic [QB-1:0]         q_y_in,
	output rstc_pkg::rstc_ctl_t   ctl_q,
	output logic [SIDE_W-1:0]     side_q,
	output logic [NNW-1:0]        den_q,
	output logic [REMW-1:0]       rem_x_q,
	output logic [REMW-1:0]       rem_y_q,
	output logic [QB-1:0]         q_x_q,
	output logic [QB-1:0]         q_y_q
);
	import rstc_pkg::*;

	logic [REMW:0]   dsh;
	logic [REMW:0]   trial_x, trial_y;
	logic [QB-1:0]   q_x_nxt, q_y_nxt;
	logic [REMW-1:0] rem_x_nxt, rem_y_nxt;

	// one restoring step on both lanes, divisor weighted by 2^SH
	assign dsh     = {{(REMW + 1 - NNW){1'b0}}, den_in} << SH;
	assign trial_x = {1'b0, rem_x_in} - dsh;
	assign trial_y = {1'b0, rem_y_in} - dsh;

	always_comb begin
		q_x_nxt     = q_x_in;
		q_y_nxt     = q_y_in;
		q_x_nxt[SH] = !trial_x[REMW];
		q_y_nxt[SH] = !trial_y[REMW];
		rem_x_nxt   = trial_x[REMW] ? rem_x_in : trial_x[REMW-1:0];
		rem_y_nxt   = trial_y[REMW] ? rem_y_in : trial_y[REMW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q  <= side_in;
			den_q   <= den_in;
			rem_x_q <= rem_x_nxt;
			rem_y_q <= rem_y_nxt;
			q_x_q   <= q_x_nxt;
			q_y_q   <= q_y_nxt;
		end
	end

endmodule

// ===== src/rect_slope_triangle_collision_core.sv =====
// Box against slope triangle collision, fully pipelined.
// Pipeline from input item to result item:
//   seven geometry and multiply stages, one divider cell per quotient bit, output register.
// Throughput: one item per cycle; each stage stalls only when the one after it is full.
// Reset (arst_n, asynchronous, active low) clears all valid bits; data registers are not reset.
module rect_slope_triangle_collision_core #(
	parameter int COORD_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic signed [COORD_BITS-1:0] rect_right,
	input  logic signed [COORD_BITS-1:0] rect_bottom,
	input  logic signed [COORD_BITS-1:0] tri_left,
	input  logic signed [COORD_BITS-1:0] tri_top,
	input  logic signed [COORD_BITS-1:0] tri_right,
	input  logic signed [COORD_BITS-1:0] tri_bottom,
	input  logic [1:0]                   slope_direction,
	input  logic [2:0]                   deform_mode,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic                         x_is_right,
	output logic signed [COORD_BITS:0]   x_limit,
	output logic                         y_is_bottom,
	output logic signed [COORD_BITS:0]   y_limit
);
	import rstc_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int D      = C + 1;      // coordinate differences
	localparam int PW     = 2 * D;      // products, n.n and d
	localparam int REMW   = 3 * D;      // |n_i * d|
	localparam int QB     = C + 2;      // push-out magnitude is below 2^(C+2)
	localparam int SIDE_W = 2 * C;
	localparam int SW     = C + 4;      // limit sum before saturation

	// stage enables, back to front
	logic en_out, en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [QB-1:0] en_c;

	// ---------------- stage 1: overlap, edge rejection, half spans
	logic signed [C-1:0] rl_s1, rt_s1, rr_s1, rb_s1, tl_s1, tt_s1, tr_s1, tb_s1;
	logic [1:0]          dir_s1;
	logic [2:0]          mode_s1;
	logic                rej_s1;
	logic signed [C:0]   dxh_s1, dyh_s1;
	logic signed [C:0]   dx_in, dy_in;
	logic                ov_rej, edge_rej;

	assign dx_in    = tri_right - tri_left;
	assign dy_in    = tri_bottom - tri_top;
	assign ov_rej   = (rect_right < tri_left) || (rect_left > tri_right) ||
	                  (rect_bottom < tri_top) || (rect_top > tri_bottom);
	// solid west corners reject past the left edge, east ones past the right
	assign edge_rej = (slope_direction == DIR_SW || slope_direction == DIR_NW) ?
	                  (rect_left < tri_left) : (rect_right > tri_right);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rl_s1   <= rect_left;
			rt_s1   <= rect_top;
			rr_s1   <= rect_right;
			rb_s1   <= rect_bottom;
			tl_s1   <= tri_left;
			tt_s1   <= tri_top;
			tr_s1   <= tri_right;
			tb_s1   <= tri_bottom;
			dir_s1  <= slope_direction;
			mode_s1 <= deform_mode;
			rej_s1  <= ov_rej || edge_rej;
			// halve toward zero
			dxh_s1  <= (dx_in >>> 1) + (C + 1)'(dx_in[C] & dx_in[0]);
			dyh_s1  <= (dy_in >>> 1) + (C + 1)'(dy_in[C] & dy_in[0]);
		end
	end

	// ---------------- stage 2: deformed slope ends
	logic signed [C-1:0] rl_s2, rt_s2, rr_s2, rb_s2;
	logic signed [C-1:0] s1x_s2, s1y_s2, s2x_s2, s2y_s2;
	logic [1:0]          dir_s2;
	logic                rej_s2;
	logic signed [C:0]   xmid, ymid;
	logic signed [C-1:0] s1x, s1y, s2x, s2y;

	assign xmid = tl_s1 + dxh_s1;
	assign ymid = tt_s1 + dyh_s1;

	always_comb begin
		s1x = tl_s1;
		s1y = tt_s1;
		s2x = tr_s1;
		s2y = tb_s1;
		unique case (mode_s1)
			MODE_LEFT_HALF:   s1y = ymid[C-1:0];
			MODE_RIGHT_HALF:  s2y = ymid[C-1:0];
			MODE_BOTTOM_HALF: s2x = xmid[C-1:0];
			MODE_TOP_HALF:    s1x = xmid[C-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rl_s2  <= rl_s1;
			rt_s2  <= rt_s1;
			rr_s2  <= rr_s1;
			rb_s2  <= rb_s1;
			s1x_s2 <= s1x;
			s1y_s2 <= s1y;
			s2x_s2 <= s2x;
			s2y_s2 <= s2y;
			dir_s2 <= dir_s1;
			rej_s2 <= rej_s1;
		end
	end

	// ---------------- stage 3: slope normal and corner offset
	logic signed [C-1:0] rl_s3, rt_s3, rr_s3, rb_s3;
	logic signed [D-1:0] nx_s3, ny_s3, ex_s3, ey_s3;
	logic                rej_s3;
	logic signed [C-1:0] ax, ay, bx, by, px, py;

	always_comb begin
		unique case (dir_s2)
			DIR_SW: begin
				px = rl_s2;  py = rb_s2;
				ax = s1x_s2; ay = s1y_s2; bx = s2x_s2; by = s2y_s2;
			end
			DIR_NE: begin
				px = rr_s2;  py = rt_s2;
				ax = s2x_s2; ay = s2y_s2; bx = s1x_s2; by = s1y_s2;
			end
			DIR_SE: begin
				px = rr_s2;  py = rb_s2;
				ax = s1x_s2; ay = s2y_s2; bx = s2x_s2; by = s1y_s2;
			end
			default: begin
				px = rl_s2;  py = rt_s2;
				ax = s2x_s2; ay = s1y_s2; bx = s1x_s2; by = s2y_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rl_s3  <= rl_s2;
			rt_s3  <= rt_s2;
			rr_s3  <= rr_s2;
			rb_s3  <= rb_s2;
			nx_s3  <= D'(by) - D'(ay);
			ny_s3  <= D'(ax) - D'(bx);
			ex_s3  <= D'(bx) - D'(px);
			ey_s3  <= D'(by) - D'(py);
			rej_s3 <= rej_s2;
		end
	end

	// ---------------- stage 4: products
	logic signed [C-1:0]  rl_s4, rt_s4, rr_s4, rb_s4;
	logic signed [PW-1:0] nxx_s4, nyy_s4, dxp_s4, dyp_s4;
	logic [D-1:0]         anx_s4, any_s4;
	logic                 nxneg_s4, nyneg_s4, rej_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rl_s4    <= rl_s3;
			rt_s4    <= rt_s3;
			rr_s4    <= rr_s3;
			rb_s4    <= rb_s3;
			nxx_s4   <= nx_s3 * nx_s3;
			nyy_s4   <= ny_s3 * ny_s3;
			dxp_s4   <= nx_s3 * ex_s3;
			dyp_s4   <= ny_s3 * ey_s3;
			anx_s4   <= nx_s3[D-1] ? D'(-nx_s3) : D'(nx_s3);
			any_s4   <= ny_s3[D-1] ? D'(-ny_s3) : D'(ny_s3);
			nxneg_s4 <= nx_s3[D-1];
			nyneg_s4 <= ny_s3[D-1];
			// zero normal: degenerate triangle
			rej_s4   <= rej_s3 || (nx_s3 == '0 && ny_s3 == '0);
		end
	end

	// ---------------- stage 5: n.n and d
	logic signed [C-1:0] rl_s5, rt_s5, rr_s5, rb_s5;
	logic [PW-1:0]       nn_s5, dm_s5;
	logic [D-1:0]        anx_s5, any_s5;
	logic                nxneg_s5, nyneg_s5, hit_s5;
	logic signed [PW:0]  dsum;

	assign dsum = dxp_s4 + dyp_s4;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rl_s5    <= rl_s4;
			rt_s5    <= rt_s4;
			rr_s5    <= rr_s4;
			rb_s5    <= rb_s4;
			nn_s5    <= nxx_s4[PW-1:0] + nyy_s4[PW-1:0];
			dm_s5    <= dsum[PW-1:0];
			anx_s5   <= anx_s4;
			any_s5   <= any_s4;
			nxneg_s5 <= nxneg_s4;
			nyneg_s5 <= nyneg_s4;
			hit_s5   <= !rej_s4 && !dsum[PW];
		end
	end

	// ---------------- stage 6: partial products of |n_i| * d
	logic [PW-1:0]      pxl_s6, pxh_s6, pyl_s6, pyh_s6, nn_s6;
	logic [SIDE_W-1:0]  side_s6;
	rstc_ctl_t          ctl_s6;
	logic               dnz;

	assign dnz = (dm_s5 != '0);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pxl_s6 <= anx_s5 * dm_s5[D-1:0];
			pxh_s6 <= anx_s5 * dm_s5[PW-1:D];
			pyl_s6 <= any_s5 * dm_s5[D-1:0];
			pyh_s6 <= any_s5 * dm_s5[PW-1:D];
			nn_s6  <= nn_s5;
			// a negative numerator picks the right and bottom edges
			side_s6 <= {(nxneg_s5 && dnz) ? rr_s5 : rl_s5,
			            (nyneg_s5 && dnz) ? rb_s5 : rt_s5};
			ctl_s6  <= '{valid: 1'b1, hit: hit_s5,
			             x_neg: nxneg_s5 && dnz, y_neg: nyneg_s5 && dnz};
		end
	end

	// ---------------- stage 7: full numerators
	logic [REMW-1:0]   numx_s7, numy_s7;
	logic [PW-1:0]     nn_s7;
	logic [SIDE_W-1:0] side_s7;
	rstc_ctl_t         ctl_s7, ctl_s7_v;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			numx_s7 <= REMW'(pxl_s6) + {pxh_s6[REMW-D-1:0], {D{1'b0}}};
			numy_s7 <= REMW'(pyl_s6) + {pyh_s6[REMW-D-1:0], {D{1'b0}}};
			nn_s7   <= nn_s6;
			side_s7 <= side_s6;
			ctl_s7  <= ctl_s6;
		end
	end

	always_comb begin
		ctl_s7_v       = ctl_s7;
		ctl_s7_v.valid = v_s7;
	end

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// ---------------- divider chain, one quotient bit per cell, MSB first
	rstc_ctl_t         ctl_c  [QB];
	logic [SIDE_W-1:0] side_c [QB];
	logic [PW-1:0]     den_c  [QB];
	logic [REMW-1:0]   remx_c [QB];
	logic [REMW-1:0]   remy_c [QB];
	logic [QB-1:0]     qx_c   [QB];
	logic [QB-1:0]     qy_c   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_cell
		if (k == QB - 1) begin : g_last
			assign en_c[k] = !ctl_c[k].valid || en_out;
		end else begin : g_mid
			assign en_c[k] = !ctl_c[k].valid || en_c[k+1];
		end

		if (k == 0) begin : g_first
			rstc_div_cell #(
				.REMW(REMW), .NNW(PW), .QB(QB), .SIDE_W(SIDE_W), .SH(QB - 1)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en_c[k]),
				.ctl_in(ctl_s7_v), .side_in(side_s7), .den_in(nn_s7),
				.rem_x_in(numx_s7), .rem_y_in(numy_s7),
				.q_x_in('0), .q_y_in('0),
				.ctl_q(ctl_c[k]), .side_q(side_c[k]), .den_q(den_c[k]),
				.rem_x_q(remx_c[k]), .rem_y_q(remy_c[k]),
				.q_x_q(qx_c[k]), .q_y_q(qy_c[k])
			);
		end else begin : g_next
			rstc_div_cell #(
				.REMW(REMW), .NNW(PW), .QB(QB), .SIDE_W(SIDE_W), .SH(QB - 1 - k)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en_c[k]),
				.ctl_in(ctl_c[k-1]), .side_in(side_c[k-1]), .den_in(den_c[k-1]),
				.rem_x_in(remx_c[k-1]), .rem_y_in(remy_c[k-1]),
				.q_x_in(qx_c[k-1]), .q_y_in(qy_c[k-1]),
				.ctl_q(ctl_c[k]), .side_q(side_c[k]), .den_q(den_c[k]),
				.rem_x_q(remx_c[k]), .rem_y_q(remy_c[k]),
				.q_x_q(qx_c[k]), .q_y_q(qy_c[k])
			);
		end
	end

	// enables: a stage moves when it is empty or the next one moves
	assign en_out   = !out_valid || out_ready;
	assign en_s7    = !v_s7 || en_c[0];
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// ---------------- output: signed push-out added to chosen edge, saturated
	rstc_ctl_t           ctl_l;
	logic signed [C-1:0] xbase, ybase;
	logic signed [QB:0]  ox, oy;
	logic signed [SW-1:0] xsum, ysum;
	logic signed [C:0]   xsat, ysat;

	assign ctl_l = ctl_c[QB-1];
	assign xbase = side_c[QB-1][SIDE_W-1:C];
	assign ybase = side_c[QB-1][C-1:0];
	assign ox    = ctl_l.x_neg ? -$signed({1'b0, qx_c[QB-1]}) : $signed({1'b0, qx_c[QB-1]});
	assign oy    = ctl_l.y_neg ? -$signed({1'b0, qy_c[QB-1]}) : $signed({1'b0, qy_c[QB-1]});
	assign xsum  = SW'(xbase) + SW'(ox);
	assign ysum  = SW'(ybase) + SW'(oy);

	always_comb begin
		if (xsum[SW-1:C] == '0 || xsum[SW-1:C] == '1) begin
			xsat = xsum[C:0];
		end else begin
			xsat = {xsum[SW-1], {C{!xsum[SW-1]}}};
		end
		if (ysum[SW-1:C] == '0 || ysum[SW-1:C] == '1) begin
			ysat = ysum[C:0];
		end else begin
			ysat = {ysum[SW-1], {C{!ysum[SW-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= ctl_l.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hit         <= ctl_l.hit;
			x_is_right  <= ctl_l.hit && ctl_l.x_neg;
			y_is_bottom <= ctl_l.hit && ctl_l.y_neg;
			x_limit     <= ctl_l.hit ? xsat : '0;
			y_limit     <= ctl_l.hit ? ysat : '0;
		end
	end

`ifndef SYNTHESIS
	// an empty output register lets the whole pipe move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// a miss carries all-zero limit fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (x_limit == '0 && y_limit == '0 &&
		                         !x_is_right && !y_is_bottom))
		else $error("miss with non-zero limits");

	// last cell stalls only behind a full, stalled output
	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_c[QB-1].valid && !en_c[QB-1]) |-> (out_valid && !out_ready))
		else $error("divider chain stalled without back-pressure");
`endif

endmodule
